### rtl/dtq_pkg.sv
`timescale 1ns / 1ps
package dtq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SORT   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic        typ;
        logic [31:0] rel;
        logic [31:0] dl;
        logic [31:0] cmp;
    } t_rec;

    // controller to datapath
    typedef struct packed {
        logic exec;       // run a push, pop or remove on the current beat
        logic sort_step;  // one odd-even exchange pass
        logic phase;      // 0: pairs from even index, 1: from odd index
        logic sort_done;  // load the sort result
    } t_cmd;

endpackage

### rtl/dtq_if.sv
`timescale 1ns / 1ps
interface dtq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] task_id;
    logic        task_type;
    logic [31:0] rel_tick;
    logic [31:0] deadline;
    logic [31:0] done_tick;

    modport source (output valid, op, task_id, task_type, rel_tick, deadline,
                    done_tick, input ready);
    modport sink (input valid, op, task_id, task_type, rel_tick, deadline,
                  done_tick, output ready);
endinterface

interface dtq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_task_id;
    logic        out_task_type;
    logic [31:0] out_rel_tick;
    logic [31:0] out_deadline;
    logic [31:0] out_done_tick;
    logic [4:0]  entry_count;

    modport source (output valid, status, out_task_id, out_task_type, out_rel_tick,
                    out_deadline, out_done_tick, entry_count, input ready);
    modport sink (input valid, status, out_task_id, out_task_type, out_rel_tick,
                  out_deadline, out_done_tick, entry_count, output ready);
endinterface

### rtl/deadline_task_queue.sv
`timescale 1ns / 1ps
// Channel   Dir   Handshake      Beat contents
// i_in      in    valid/ready    op, task_id, task_type, rel_tick, deadline,
//                                done_tick
// o_out     out   valid/ready    status, out_task_id, out_task_type,
//                                out_rel_tick, out_deadline,
//                                out_done_tick, entry_count
//
// Push, pop and remove act on the register chain as the beat is taken; the result is
// registered and shown the next cycle.
// Sort runs DEPTH odd-even exchange passes, one per cycle, counted by the pass
// counter; no new beat is taken while the sort runs.
// Reset (synchronous, active low) clears the entry count and the result valid.
// A new beat is taken while the result register is free or being emptied.
module deadline_task_queue (
    input logic        i_clk,
    input logic        i_rst_n,
    dtq_in_if.sink     i_in,
    dtq_out_if.source  o_out
);
    dtq_pkg::t_cmd cmd;
    dtq_pkg::t_rec in_rec;
    dtq_pkg::t_rec res_rec;

    // pack the incoming beat into one record
    assign in_rec.id  = i_in.task_id;
    assign in_rec.typ = i_in.task_type;
    assign in_rec.rel = i_in.rel_tick;
    assign in_rec.dl  = i_in.deadline;
    assign in_rec.cmp = i_in.done_tick;

    dtq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    dtq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_op     (i_in.op),
        .i_rec    (in_rec),
        .o_status (o_out.status),
        .o_rec    (res_rec),
        .o_count  (o_out.entry_count)
    );

    // unpack the result record onto the output beat
    assign o_out.out_task_id   = res_rec.id;
    assign o_out.out_task_type = res_rec.typ;
    assign o_out.out_rel_tick  = res_rec.rel;
    assign o_out.out_deadline  = res_rec.dl;
    assign o_out.out_done_tick = res_rec.cmp;
endmodule

### rtl/dtq_ctrl.sv
`timescale 1ns / 1ps
module dtq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output dtq_pkg::t_cmd o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SORT = 1'b1;

    logic                     r_state, n_state;
    logic [dtq_pkg::IDX_W-1:0] r_pass, n_pass;
    logic                     r_out_valid, n_out_valid;
    logic                     accept;
    logic                     last_pass;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign last_pass   = (r_pass == dtq_pkg::IDX_W'(dtq_pkg::DEPTH - 1));
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == dtq_pkg::OP_SORT) begin
                        n_state = S_SORT;
                        n_pass  = '0;
                    end else begin
                        o_cmd.exec  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.phase     = r_pass[0];
                n_pass          = r_pass + 1'b1;
                if (last_pass) begin
                    o_cmd.sort_done = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

### rtl/dtq_datapath.sv
`timescale 1ns / 1ps
module dtq_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dtq_pkg::t_cmd i_cmd,
    input  logic [1:0]    i_op,
    input  dtq_pkg::t_rec i_rec,
    output logic [1:0]    o_status,
    output dtq_pkg::t_rec o_rec,
    output logic [4:0]    o_count
);
    localparam int D = dtq_pkg::DEPTH;

    dtq_pkg::t_rec             r_cell [D];
    dtq_pkg::t_rec             n_cell [D];
    logic [dtq_pkg::CNT_W-1:0] r_count, n_count;
    logic [1:0]                r_status, n_status;
    dtq_pkg::t_rec             r_res, n_res;
    logic [D-1:0]              hit, above, first;
    dtq_pkg::t_rec             hit_rec;
    logic                      full, empty;

    assign full  = (r_count == dtq_pkg::CNT_W'(D));
    assign empty = (r_count == '0);

    // match and first-hit mask for remove
    always_comb begin
        hit_rec = '0;
        for (int i = 0; i < D; i++) begin
            hit[i] = (dtq_pkg::CNT_W'(i) < r_count) && (r_cell[i].id == i_rec.id);
        end
        above[0] = hit[0];
        first[0] = hit[0];
        for (int i = 1; i < D; i++) begin
            above[i] = above[i-1] | hit[i];
            first[i] = hit[i] & ~above[i-1];
        end
        for (int i = 0; i < D; i++) begin
            if (first[i]) hit_rec = hit_rec | r_cell[i];
        end
    end

    always_comb begin
        n_cell   = r_cell;
        n_count  = r_count;
        n_status = r_status;
        n_res    = r_res;
        if (i_cmd.exec) begin
            n_status = dtq_pkg::ST_OK;
            n_res    = '0;
            case (i_op)
                dtq_pkg::OP_PUSH: begin
                    if (full) begin
                        n_status = dtq_pkg::ST_FULL;
                    end else begin
                        for (int i = 1; i < D; i++) n_cell[i] = r_cell[i-1];
                        n_cell[0] = i_rec;
                        n_count   = r_count + 1'b1;
                    end
                end
                dtq_pkg::OP_POP: begin
                    if (empty) begin
                        n_status = dtq_pkg::ST_EMPTY;
                    end else begin
                        n_res = r_cell[0];
                        for (int i = 0; i < D - 1; i++) n_cell[i] = r_cell[i+1];
                        n_count = r_count - 1'b1;
                    end
                end
                dtq_pkg::OP_REMOVE: begin
                    if (!above[D-1]) begin
                        n_status = dtq_pkg::ST_NOTFOUND;
                    end else begin
                        n_res = hit_rec;
                        for (int i = 0; i < D - 1; i++) begin
                            if (above[i]) n_cell[i] = r_cell[i+1];
                        end
                        n_count = r_count - 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.sort_step) begin
            // strict compare keeps equal deadlines in order
            for (int j = 0; j < D - 1; j++) begin
                if ((j[0] == i_cmd.phase) && (dtq_pkg::CNT_W'(j + 1) < r_count)
                    && (r_cell[j].dl > r_cell[j+1].dl)) begin
                    n_cell[j]   = r_cell[j+1];
                    n_cell[j+1] = r_cell[j];
                end
            end
        end
        if (i_cmd.sort_done) begin
            n_status = dtq_pkg::ST_OK;
            n_res    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_status <= n_status;
        r_res    <= n_res;
    end

    assign o_status = r_status;
    assign o_rec    = r_res;
    assign o_count  = 5'(r_count);
endmodule
